### rtl/core/spq_pkg.sv
// shared types and codes for the stable priority queue
`default_nettype none

package spq_pkg;

   localparam int ID_BITS     = 16;
   localparam int STATUS_BITS = 2;

   // operation codes on the request side
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_POPPED   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;
      logic pop;
   } spq_cmd_type;

endpackage

`default_nettype wire

### rtl/core/spq_cell.sv
// one slot of the shift-register queue: holds an entry and trades with its neighbors
`default_nettype none

module spq_cell #(
   parameter int PRIO_W = 3
) (
   input  wire                         clock,
   input  wire                         reset,
   input  spq_pkg::spq_cmd_type        cmd,
   input  wire  [PRIO_W-1:0]           new_prio,
   input  wire  [spq_pkg::ID_BITS-1:0] new_id,
   input  wire                         left_gt,
   input  wire                         left_valid,
   input  wire  [PRIO_W-1:0]           left_prio,
   input  wire  [spq_pkg::ID_BITS-1:0] left_id,
   input  wire                         right_valid,
   input  wire  [PRIO_W-1:0]           right_prio,
   input  wire  [spq_pkg::ID_BITS-1:0] right_id,
   output logic                        gt,
   output logic                        valid,
   output logic [PRIO_W-1:0]           prio,
   output logic [spq_pkg::ID_BITS-1:0] id
);
   import spq_pkg::*;

   logic                valid_ff, valid_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [ID_BITS-1:0]  id_ff, id_in;

   // empty slots count as holding a larger code, so the new word lands after equals
   assign gt = !valid_ff || (prio_ff > new_prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      id_in    = id_ff;
      if (cmd.ins && gt) begin
         valid_in = 1'b1;
         if (left_gt) begin
            // an empty left neighbor hands over an empty slot
            valid_in = left_valid;
            prio_in  = left_prio;
            id_in    = left_id;
         end else begin
            prio_in = new_prio;
            id_in   = new_id;
         end
      end else if (cmd.pop) begin
         valid_in = right_valid;
         prio_in  = right_prio;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff <= prio_in;
      id_ff   <= id_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign id    = id_ff;

endmodule

`default_nettype wire

### rtl/core/stable_priority_queue_core.sv
// Stable priority queue built as a chain of compare-and-shift cells.
//
// Request channel (req_*): each word is an insert (kind 0) carrying a
// priority code and an identifier, or a pop (kind 1). Lower codes leave
// first; equal codes leave in arrival order.
// Result channel (rsp_*): exactly one word per request, carrying the status
// (inserted, popped, pop on empty, insert dropped full) and, for a pop, the
// code and identifier of the removed head entry. Capacity is CAPACITY cells.
// The registered result shows in the cycle after its request is taken. One
// request is taken per cycle while req_stall is low, as all cells compare
// against the new code at once and shift left or right in the same edge.
// Reset clears every cell's valid bit, leaving the queue empty and the
// result register empty. While the receiver stalls a waiting result, the
// request side stalls too; a result that is taken frees the register for a
// new request in the same cycle.
`default_nettype none

module stable_priority_queue_core #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 3
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_kind,
   input  wire  [PRIORITY_BITS-1:0]       req_priority_code,
   input  wire  [spq_pkg::ID_BITS-1:0]    req_entry_id,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [spq_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [PRIORITY_BITS-1:0]       rsp_out_priority,
   output logic [spq_pkg::ID_BITS-1:0]    rsp_out_id
);
   import spq_pkg::*;

   logic                     gt_w    [CAPACITY];
   logic                     valid_w [CAPACITY];
   logic [PRIORITY_BITS-1:0] prio_w  [CAPACITY];
   logic [ID_BITS-1:0]       id_w    [CAPACITY];

   spq_cmd_type cmd;
   logic        accept;
   logic        full;
   logic        empty;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = valid_w[CAPACITY-1];
   assign empty     = !valid_w[0];

   assign cmd.ins = accept && (req_kind == KIND_INSERT) && !full;
   assign cmd.pop = accept && (req_kind == KIND_POP) && !empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                     l_gt;
         logic                     l_valid;
         logic [PRIORITY_BITS-1:0] l_prio;
         logic [ID_BITS-1:0]       l_id;
         logic                     r_valid;
         logic [PRIORITY_BITS-1:0] r_prio;
         logic [ID_BITS-1:0]       r_id;

         if (gi == 0) begin : g_head
            assign l_gt    = 1'b0;
            assign l_valid = 1'b0;
            assign l_prio  = '0;
            assign l_id    = '0;
         end else begin : g_mid
            assign l_gt    = gt_w[gi-1];
            assign l_valid = valid_w[gi-1];
            assign l_prio  = prio_w[gi-1];
            assign l_id    = id_w[gi-1];
         end

         if (gi == CAPACITY-1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_prio  = '0;
            assign r_id    = '0;
         end else begin : g_body
            assign r_valid = valid_w[gi+1];
            assign r_prio  = prio_w[gi+1];
            assign r_id    = id_w[gi+1];
         end

         spq_cell #(
            .PRIO_W (PRIORITY_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .new_prio    (req_priority_code),
            .new_id      (req_entry_id),
            .left_gt     (l_gt),
            .left_valid  (l_valid),
            .left_prio   (l_prio),
            .left_id     (l_id),
            .right_valid (r_valid),
            .right_prio  (r_prio),
            .right_id    (r_id),
            .gt          (gt_w[gi]),
            .valid       (valid_w[gi]),
            .prio        (prio_w[gi]),
            .id          (id_w[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_id_in     = rsp_id_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_prio_in  = '0;
         rsp_id_in    = '0;
         if (req_kind == KIND_INSERT) begin
            rsp_status_in = full ? ST_FULL : ST_INSERTED;
         end else if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_POPPED;
            rsp_prio_in   = prio_w[0];
            rsp_id_in     = id_w[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_id       = rsp_id_ff;

endmodule

`default_nettype wire

### dv/spq_order_check.sv
`timescale 1ns / 1ps
// checker that mirrors the stable priority queue and compares every result word
module spq_order_check #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 3
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire                             req_kind,
   input  wire  [PRIORITY_BITS-1:0]        req_priority_code,
   input  wire  [spq_pkg::ID_BITS-1:0]     req_entry_id,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire  [spq_pkg::STATUS_BITS-1:0] rsp_status,
   input  wire  [PRIORITY_BITS-1:0]        rsp_out_priority,
   input  wire  [spq_pkg::ID_BITS-1:0]     rsp_out_id,
   output int                              mismatch_count,
   output int                              waiting_count
);
   import spq_pkg::*;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] code;
      logic [ID_BITS-1:0]       id;
   } entry_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [PRIORITY_BITS-1:0] code;
      logic [ID_BITS-1:0]       id;
   } reply_type;

   entry_type held_entries[$];
   reply_type due_replies[$];
   int        mismatches = 0;

   function automatic reply_type serve_request(input logic kind,
                                               input logic [PRIORITY_BITS-1:0] code,
                                               input logic [ID_BITS-1:0] id);
      reply_type reply;
      entry_type fresh;
      int        pos;
      reply = '0;
      fresh.code = code;
      fresh.id = id;
      pos = 0;
      if (kind == KIND_INSERT) begin
         if (held_entries.size() >= CAPACITY) begin
            reply.status = ST_FULL;
         end else begin
            // equal codes go behind the ones already stored
            while (pos < held_entries.size() && held_entries[pos].code <= code) pos++;
            held_entries.insert(pos, fresh);
            reply.status = ST_INSERTED;
         end
      end else if (held_entries.size() == 0) begin
         reply.status = ST_EMPTY;
      end else begin
         reply.status = ST_POPPED;
         reply.code = held_entries[0].code;
         reply.id = held_entries[0].id;
         void'(held_entries.pop_front());
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type due;
      if (reset) begin
         held_entries.delete();
         due_replies.delete();
      end else begin
         // result side first: a word taken on this edge has no result yet
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $display("%0t: unexpected result word, status %0h priority %0h id %0h",
                        $time, rsp_status, rsp_out_priority, rsp_out_id);
               mismatches++;
            end else begin
               due = due_replies.pop_front();
               if (rsp_status !== due.status) begin
                  $display("%0t: status expected %0h actual %0h",
                           $time, due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_out_priority !== due.code) begin
                  $display("%0t: out_priority expected %0h actual %0h",
                           $time, due.code, rsp_out_priority);
                  mismatches++;
               end
               if (rsp_out_id !== due.id) begin
                  $display("%0t: out_id expected %0h actual %0h",
                           $time, due.id, rsp_out_id);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_replies.push_back(serve_request(req_kind, req_priority_code, req_entry_id));
         end
      end
      mismatch_count <= mismatches;
      waiting_count <= due_replies.size();
   end

endmodule

### dv/tb_stable_priority_queue_core.sv
`timescale 1ns / 1ps
// testbench top: drives insert and pop words into the queue and gives the verdict
module tb_stable_priority_queue_core;
   import spq_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 3;
   localparam int RANDOM_WORDS  = 1925;
   localparam int QUIET_LIMIT   = 2000;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_kind = KIND_INSERT;
   logic [PRIORITY_BITS-1:0] req_priority_code = '0;
   logic [ID_BITS-1:0]       req_entry_id = '0;
   logic                     rsp_stall = 1'b0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [PRIORITY_BITS-1:0] rsp_out_priority;
   logic [ID_BITS-1:0]       rsp_out_id;

   int mismatch_count;
   int waiting_count;
   int quiet_cycles = 0;
   bit calm = 1'b0;

   stable_priority_queue_core #(
      .CAPACITY(CAPACITY),
      .PRIORITY_BITS(PRIORITY_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_priority_code(req_priority_code),
      .req_entry_id(req_entry_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority),
      .rsp_out_id(rsp_out_id)
   );

   spq_order_check #(
      .CAPACITY(CAPACITY),
      .PRIORITY_BITS(PRIORITY_BITS)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_priority_code(req_priority_code),
      .req_entry_id(req_entry_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority),
      .rsp_out_id(rsp_out_id),
      .mismatch_count(mismatch_count),
      .waiting_count(waiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
   end

   // nothing taken on either side for too long means the block is hung
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_word(input logic kind, input logic [PRIORITY_BITS-1:0] code,
                            input logic [ID_BITS-1:0] id);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_priority_code <= code;
      req_entry_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int unsigned              draw;
      int unsigned              insert_pct;
      logic [PRIORITY_BITS-1:0] code_base;
      logic [PRIORITY_BITS-1:0] code;
      logic                     kind;
      insert_pct = 50;
      code_base = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // pop on an empty queue, then extremes and repeated codes
      send_word(KIND_POP, 3'd7, 16'hffff);
      send_word(KIND_INSERT, 3'd7, 16'hffff);
      send_word(KIND_INSERT, 3'd0, 16'h0000);
      send_word(KIND_INSERT, 3'd3, 16'h1111);
      send_word(KIND_INSERT, 3'd3, 16'h2222);
      send_word(KIND_INSERT, 3'd0, 16'h0001);
      send_word(KIND_INSERT, 3'd7, 16'h0002);
      send_word(KIND_INSERT, 3'd3, 16'h3333);
      for (int n = 0; n < 9; n++) begin
         send_word(KIND_INSERT, n[2:0], {12'h010, n[3:0]});
      end
      // queue is full now, both of these get dropped
      send_word(KIND_INSERT, 3'd5, 16'habcd);
      send_word(KIND_INSERT, 3'd0, 16'h0000);
      repeat (3) send_word(KIND_POP, 3'd0, 16'h0000);

      // phases lean toward inserts or pops so the queue swings between full and empty
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) begin
            draw = $urandom_range(2);
            insert_pct = (draw == 0) ? 15 : (draw == 1) ? 50 : 85;
            draw = $urandom();
            code_base = draw[2:0];
         end
         calm = (n >= 900 && n < 1200);
         draw = $urandom();
         // half the words crowd two neighboring codes to stress arrival order
         code = draw[0] ? code_base + {2'b00, draw[1]} : draw[4:2];
         kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_POP;
         send_word(kind, code, draw[31:16]);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
